FILE: design/assert_macros.svh
// assertion macros shared by the console rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge out of reset
`define TCC_ASSERT(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("console assertion failed");

// antecedent implies consequent in the same cycle
`define TCC_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("console assertion failed");

// antecedent implies consequent in the next cycle
`define TCC_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("console assertion failed");

`else

`define TCC_ASSERT(label, clk, rst, expr)
`define TCC_IMPLY(label, clk, rst, ante, cons)
`define TCC_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: design/tcc_pkg.sv
// shared types and codes for the text console
`timescale 1ns / 1ps

package tcc_pkg;

  // fixed field widths
  localparam int CURSOR_W = 11;
  localparam int DATA_W   = 16;
  localparam int INDEX_W  = 11;

  // operation codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // character codes
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // color after reset and the blank cell it makes
  localparam logic [7:0]  RESET_COLOR = 8'h07;
  localparam logic [15:0] RESET_CELL  = {RESET_COLOR, CH_SPACE};

  // one result as handed from the engine to the output register
  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_position;
    logic [DATA_W-1:0]   read_data;
  } tcc_result_t;

endpackage

FILE: design/text_console_cursor_and_scroll.sv
// Text console top level: a screen of ROWS x COLUMNS cells of color and character.
// Input channel (in_valid / in_stall) carries operation, char_code and cell_index;
// operation 0 puts a character (newline, return and backspace act on the cursor),
// 1 blanks the screen in text_color and homes the cursor, 2 reads one cell.
// Every transfer in gives exactly one transfer out (out_valid / out_stall) with the
// linear cursor position after the operation and, for a read, the cell contents.
// The cfg channel (cfg_valid / cfg_ready, always ready) writes text_color.
// Sequence: a put passes EXEC and WRAP, an in-range read EXEC and RDWAIT, and an
// unused code or out-of-range read only EXEC, before DONE presents the result.
// Clear steps FILL through every cell; a put that scrolls moves the rows up
// through the memory read port in SCROLL, then blanks the bottom row in FILL.
// These sweeps are bounded by the single write port of the cell memory, which
// handles one cell per cycle.
// After reset the block sweeps all COLUMNS*ROWS cells (2000 by default) to spaces
// in color 07 with in_stall high; cfg writes are taken meanwhile.
// A result stalled at the output is held in a register; the next input may be
// taken while it waits, and its own result waits until the register frees.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_console_cursor_and_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          operation,
  input  logic [7:0]                          char_code,
  input  logic [tcc_pkg::INDEX_W-1:0]         cell_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tcc_pkg::CURSOR_W-1:0]        cursor_position,
  output logic [tcc_pkg::DATA_W-1:0]          read_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [7:0]                          cfg_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [7:0]                 text_color;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [tcc_pkg::DATA_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [tcc_pkg::DATA_W-1:0] ram_rdata;
  logic                       res_valid;
  logic                       res_take;
  tcc_pkg::tcc_result_t       res;

  // color register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tcc_pkg::RESET_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      text_color <= cfg_data;
    end
  end

  // cell memory
  tcc_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // operation sequencer
  tcc_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .char_code  (char_code),
    .cell_index (cell_index),
    .text_color (text_color),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  // output register, freed by a transfer out
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      cursor_position <= res.cursor_position;
      read_data       <= res.read_data;
    end
  end

  `TCC_IMPLY(a_out_cursor_range, clk, rst, out_valid, 32'(cursor_position) < 32'(CELLS))

endmodule

FILE: design/tcc_cell_ram.sv
// screen cell memory, one write and one registered read port
`timescale 1ns / 1ps

module tcc_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [tcc_pkg::DATA_W-1:0]  wdata,
  input  logic [AW-1:0]               raddr,
  output logic [tcc_pkg::DATA_W-1:0]  rdata
);

  logic [tcc_pkg::DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/tcc_engine.sv
// cursor tracking and cell memory sequencer: put, clear, read, scroll
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcc_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            operation,
  input  logic [7:0]                            char_code,
  input  logic [tcc_pkg::INDEX_W-1:0]           cell_index,
  input  logic [7:0]                            text_color,
  output logic                                  ram_we,
  output logic [$clog2(COLUMNS*ROWS)-1:0]       ram_waddr,
  output logic [tcc_pkg::DATA_W-1:0]            ram_wdata,
  output logic [$clog2(COLUMNS*ROWS)-1:0]       ram_raddr,
  input  logic [tcc_pkg::DATA_W-1:0]            ram_rdata,
  output logic                                  res_valid,
  input  logic                                  res_take,
  output tcc_pkg::tcc_result_t                  res
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = $clog2(CELLS + COLUMNS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int CMPW  = (PW > tcc_pkg::INDEX_W) ? PW : tcc_pkg::INDEX_W;
  localparam int CUR_W = tcc_pkg::CURSOR_W;

  typedef enum logic [2:0] {
    INIT, IDLE, EXEC, RDWAIT, WRAP, SCROLL, FILL, DONE
  } state_t;

  state_t                      state;
  logic [1:0]                  op_q;
  logic [7:0]                  ch_q;
  logic [tcc_pkg::INDEX_W-1:0] idx_q;
  logic [PW-1:0]               pos;
  logic [CW-1:0]               col;
  logic [PW-1:0]               ptr;
  logic [AW-1:0]               mv_dst;
  logic                        mv_pend;
  logic [tcc_pkg::DATA_W-1:0]  fill_word;
  logic [tcc_pkg::DATA_W-1:0]  rd_q;

  logic [tcc_pkg::DATA_W-1:0]  blank;
  logic [CW:0]                 col_inc;
  logic                        col_last;
  logic                        idx_ok;
  logic                        pos_past;
  logic [PW-1:0]               pos_dec;
  logic [PW-1:0]               ptr_back;
  logic                        is_ctrl;

  // decode helpers
  always_comb begin
    blank    = {text_color, tcc_pkg::CH_SPACE};
    col_inc  = {1'b0, col} + 1'b1;
    col_last = (col_inc == (CW+1)'(COLUMNS));
    idx_ok   = (CMPW'(idx_q) < CMPW'(CELLS));
    pos_past = (pos >= PW'(CELLS));
    pos_dec  = pos - 1'b1;
    ptr_back = ptr - PW'(COLUMNS);
    is_ctrl  = (ch_q == tcc_pkg::CH_NEWLINE) || (ch_q == tcc_pkg::CH_RETURN) ||
               (ch_q == tcc_pkg::CH_BACKSPACE);
  end

  // memory port drive
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr[AW-1:0];
    ram_wdata = fill_word;
    ram_raddr = ptr[AW-1:0];
    unique case (state)
      INIT: begin
        ram_we    = 1'b1;
        ram_wdata = tcc_pkg::RESET_CELL;
      end
      EXEC: begin
        ram_raddr = AW'(idx_q);
        if (op_q == tcc_pkg::OP_PUT) begin
          priority if (ch_q == tcc_pkg::CH_BACKSPACE) begin
            ram_we    = (col != '0);
            ram_waddr = pos_dec[AW-1:0];
            ram_wdata = blank;
          end else if (!is_ctrl) begin
            ram_we    = 1'b1;
            ram_waddr = pos[AW-1:0];
            ram_wdata = {text_color, ch_q};
          end else begin
            ram_we    = 1'b0;
          end
        end
      end
      SCROLL: begin
        ram_we    = mv_pend;
        ram_waddr = mv_dst;
        ram_wdata = ram_rdata;
      end
      FILL: begin
        ram_we    = 1'b1;
      end
      default: begin
        ram_we    = 1'b0;
      end
    endcase
  end

  // sequencer and cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= INIT;
      ptr     <= '0;
      pos     <= '0;
      col     <= '0;
      mv_pend <= 1'b0;
    end else begin
      unique case (state)
        INIT: begin
          ptr <= ptr + 1'b1;
          if (ptr == PW'(CELLS - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          op_q  <= operation;
          ch_q  <= char_code;
          idx_q <= cell_index;
          rd_q  <= '0;
          if (in_valid) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          unique case (op_q)
            tcc_pkg::OP_PUT: begin
              priority if (ch_q == tcc_pkg::CH_NEWLINE) begin
                pos <= pos - PW'(col) + PW'(COLUMNS);
                col <= '0;
              end else if (ch_q == tcc_pkg::CH_RETURN) begin
                pos <= pos - PW'(col);
                col <= '0;
              end else if (ch_q == tcc_pkg::CH_BACKSPACE) begin
                if (col != '0) begin
                  pos <= pos_dec;
                  col <= col - 1'b1;
                end
              end else begin
                pos <= pos + 1'b1;
                col <= col_last ? '0 : col_inc[CW-1:0];
              end
              state <= WRAP;
            end
            tcc_pkg::OP_CLEAR: begin
              pos       <= '0;
              col       <= '0;
              ptr       <= '0;
              fill_word <= blank;
              state     <= FILL;
            end
            tcc_pkg::OP_READ: begin
              state <= idx_ok ? RDWAIT : DONE;
            end
            default: begin
              state <= DONE;
            end
          endcase
        end
        RDWAIT: begin
          rd_q  <= ram_rdata;
          state <= DONE;
        end
        WRAP: begin
          if (pos_past) begin
            pos     <= pos - PW'(COLUMNS);
            ptr     <= PW'(COLUMNS);
            mv_pend <= 1'b0;
            state   <= SCROLL;
          end else begin
            state <= DONE;
          end
        end
        SCROLL: begin
          // read one row down, write it back one row up in the next cycle
          if (ptr == PW'(CELLS)) begin
            mv_pend   <= 1'b0;
            ptr       <= PW'(CELLS - COLUMNS);
            fill_word <= blank;
            state     <= FILL;
          end else begin
            mv_pend <= 1'b1;
            mv_dst  <= ptr_back[AW-1:0];
            ptr     <= ptr + 1'b1;
          end
        end
        FILL: begin
          ptr <= ptr + 1'b1;
          if (ptr == PW'(CELLS - 1)) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (res_take) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // handshake and result
  assign in_stall            = (state != IDLE);
  assign res_valid           = (state == DONE);
  assign res.cursor_position = CUR_W'(pos);
  assign res.read_data       = rd_q;

  `TCC_IMPLY(a_pos_in_range, clk, rst, state == IDLE, pos < PW'(CELLS))
  `TCC_ASSERT(a_col_in_range, clk, rst, (CW+1)'(col) < (CW+1)'(COLUMNS))
  `TCC_IMPLY(a_write_in_range, clk, rst, ram_we, (AW+1)'(ram_waddr) < (AW+1)'(CELLS))
  `TCC_NEXT(a_accept_starts, clk, rst, in_valid && !in_stall, state == EXEC)

endmodule
